// ===== design/ppcr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the plane collision block.
`default_nettype none
package ppcr_pkg;

  localparam int POS_WIDTH   = 32;
  localparam int WIDE        = 64;
  localparam int NRM_FRAC    = 15;
  localparam int COEF_FRAC   = 16;
  localparam int RATIO_FRAC  = 24;
  localparam int NRM_WIDTH   = 16;
  localparam int FRIC_WIDTH  = 18;
  localparam int REST_WIDTH  = 17;
  localparam int IDX_WIDTH   = 3;

  // register indexes
  localparam logic [IDX_WIDTH-1:0] CFG_NORMAL_X     = 3'd0;
  localparam logic [IDX_WIDTH-1:0] CFG_NORMAL_Y     = 3'd1;
  localparam logic [IDX_WIDTH-1:0] CFG_PLANE_OFFSET = 3'd2;
  localparam logic [IDX_WIDTH-1:0] CFG_WORLD_FRIC   = 3'd3;
  localparam logic [IDX_WIDTH-1:0] CFG_WORLD_REST   = 3'd4;

  localparam logic signed [NRM_WIDTH-1:0] NORMAL_Y_RESET = 16'sd32767;

  localparam logic signed [WIDE-1:0] LIM62 = 64'sh3FFF_FFFF_FFFF_FFFF;

  // first half of a split product: two partial products and the sign
  typedef struct packed {
    logic        neg;
    logic [60:0] hi;
    logic [62:0] lo;
  } mp_t;

  // one pipeline stage of data; each stage uses the fields it needs
  typedef struct packed {
    logic signed [WIDE-1:0] px;
    logic signed [WIDE-1:0] py;
    logic signed [WIDE-1:0] qx;
    logic signed [WIDE-1:0] qy;
    logic signed [WIDE-1:0] rad;
    logic                   pinned;
    logic [FRIC_WIDTH-1:0]  lf;
    logic [REST_WIDTH-1:0]  lr;
    mp_t                    mp0;
    mp_t                    mp1;
    mp_t                    mp2;
    mp_t                    mp3;
    logic signed [WIDE-1:0] a;
    logic signed [WIDE-1:0] b;
    logic signed [WIDE-1:0] pdist;
    logic                   hit;
    logic signed [WIDE-1:0] pen;
    logic [FRIC_WIDTH-1:0]  mu;
    logic [REST_WIDTH-1:0]  e;
    logic signed [WIDE-1:0] npx;
    logic signed [WIDE-1:0] npy;
    logic signed [WIDE-1:0] vx;
    logic signed [WIDE-1:0] vy;
    logic signed [WIDE-1:0] vn;
    logic signed [WIDE-1:0] m;
    logic [WIDE-1:0]        lim;
    logic signed [WIDE-1:0] tx;
    logic signed [WIDE-1:0] ty;
    logic                   tnz;
    logic signed [WIDE-1:0] nqx;
    logic signed [WIDE-1:0] nqy;
    logic [5:0]             k;
    logic [30:0]            sx;
    logic [30:0]            sy;
    logic [61:0]            sqx;
    logic [61:0]            sqy;
    logic [WIDE-1:0]        rem;
    logic [WIDE-1:0]        res;
    logic [WIDE-1:0]        len;
    logic                   le;
    logic [WIDE-1:0]        ls;
    logic [WIDE-1:0]        drem;
    logic [RATIO_FRAC:0]    q;
  } pipe_t;

  function automatic logic signed [WIDE-1:0] clamp62(logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] r;
    r = v;
    if (v > LIM62) r = LIM62;
    if (v < -LIM62) r = -LIM62;
    return r;
  endfunction

  function automatic logic signed [WIDE-1:0] sadd(logic signed [WIDE-1:0] x,
                                                  logic signed [WIDE-1:0] y);
    return clamp62(clamp62(x) + clamp62(y));
  endfunction

  function automatic logic [61:0] mag(logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] c;
    c = clamp62(v);
    return (c < 0) ? 62'(-c) : 62'(c);
  endfunction

  // partial products of |a| * min(|b|, 2^31-1)
  function automatic mp_t mul_lo(logic signed [WIDE-1:0] x, logic signed [WIDE-1:0] y);
    mp_t p;
    logic [61:0] ma;
    logic [61:0] mb62;
    logic [30:0] mb;
    ma   = mag(x);
    mb62 = mag(y);
    mb   = (mb62 >= 62'h8000_0000) ? 31'h7FFF_FFFF : mb62[30:0];
    p.neg = (x < 0) != (y < 0);
    p.hi  = 61'(ma[61:32]) * 61'(mb);
    p.lo  = 63'(ma[31:0]) * 63'(mb);
    return p;
  endfunction

  // round to nearest (ties away), shift by s, saturate
  function automatic logic signed [WIDE-1:0] mul_hi(mp_t p, int s);
    logic [WIDE-1:0] hi64;
    logic [WIDE-1:0] lo64;
    logic [WIDE-1:0] r;
    hi64 = {3'b0, p.hi};
    lo64 = ({1'b0, p.lo} + (64'd1 << (s - 1))) >> s;
    if (hi64 >= (64'd1 << (30 + s))) begin
      r = LIM62;
    end else begin
      r = (hi64 << (32 - s)) + lo64;
      if (r > LIM62) r = LIM62;
    end
    return p.neg ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ===== design/ppcr_if.sv =====
// Request channels for particles in and collision results out.
`default_nettype none
interface ppcr_in_if #(parameter int POS_WIDTH = ppcr_pkg::POS_WIDTH);
  logic                                valid;
  logic                                ready;
  logic signed [POS_WIDTH-1:0]         pos_x;
  logic signed [POS_WIDTH-1:0]         pos_y;
  logic signed [POS_WIDTH-1:0]         prev_x;
  logic signed [POS_WIDTH-1:0]         prev_y;
  logic [POS_WIDTH-2:0]                radius;
  logic                                pinned;
  logic [ppcr_pkg::FRIC_WIDTH-1:0]     local_friction;
  logic [ppcr_pkg::REST_WIDTH-1:0]     local_restitution;

  modport source (output valid, pos_x, pos_y, prev_x, prev_y, radius, pinned,
                  local_friction, local_restitution, input ready);
  modport sink   (input valid, pos_x, pos_y, prev_x, prev_y, radius, pinned,
                  local_friction, local_restitution, output ready);
endinterface

interface ppcr_out_if #(parameter int POS_WIDTH = ppcr_pkg::POS_WIDTH);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] new_pos_x;
  logic signed [POS_WIDTH-1:0] new_pos_y;
  logic signed [POS_WIDTH-1:0] new_prev_x;
  logic signed [POS_WIDTH-1:0] new_prev_y;
  logic                        collided;

  modport source (output valid, new_pos_x, new_pos_y, new_prev_x, new_prev_y, collided,
                  input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_prev_x, new_prev_y, collided,
                  output ready);
endinterface
`default_nettype wire

// ===== design/plane_particle_collision_response_top.sv =====
// Top level: pipelined plane collision response for 2D Verlet particles.
// Throughput: one particle per cycle; each stage holds its item while the next is full.
// The 32-step square root runs two steps per stage; the ratio divide takes its whole bit at setup, then 24 fraction steps at two per stage.
// Reset clears all stage valid bits and loads the plane registers with their defaults.
`default_nettype none
module plane_particle_collision_response_top #(
  parameter int POS_WIDTH = ppcr_pkg::POS_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ppcr_in_if.sink                                particle,
  ppcr_out_if.source                             result,
  input  wire logic                              wr_en,
  input  wire logic [ppcr_pkg::IDX_WIDTH-1:0]    wr_index,
  input  wire logic [POS_WIDTH-1:0]              wr_data
);

  localparam int W          = ppcr_pkg::WIDE;
  localparam int SQRT_STEPS = 2;
  localparam int SQRT_ST    = 32 / SQRT_STEPS;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_ST     = ppcr_pkg::RATIO_FRAC / DIV_STEPS;
  localparam int S_SQRT0    = 19;
  localparam int S_LEN      = S_SQRT0 + SQRT_ST;
  localparam int S_DSET     = S_LEN + 1;
  localparam int S_DIV0     = S_DSET + 1;
  localparam int S_QMUL     = S_DIV0 + DIV_ST;
  localparam int N          = S_QMUL + 4;
  localparam logic signed [W-1:0] PMAX = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
  localparam logic signed [W-1:0] PMIN = -PMAX - 64'sd1;

  function automatic logic signed [W-1:0] satpos(logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > PMAX) r = PMAX;
    if (v < PMIN) r = PMIN;
    return r;
  endfunction

  // configuration registers
  logic signed [ppcr_pkg::NRM_WIDTH-1:0] normal_x;
  logic signed [ppcr_pkg::NRM_WIDTH-1:0] normal_y;
  logic signed [POS_WIDTH-1:0]           plane_offset;
  logic [ppcr_pkg::FRIC_WIDTH-1:0]       world_friction;
  logic [ppcr_pkg::REST_WIDTH-1:0]       world_restitution;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x          <= '0;
      normal_y          <= ppcr_pkg::NORMAL_Y_RESET;
      plane_offset      <= '0;
      world_friction    <= '0;
      world_restitution <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ppcr_pkg::CFG_NORMAL_X:     normal_x <= wr_data[ppcr_pkg::NRM_WIDTH-1:0];
        ppcr_pkg::CFG_NORMAL_Y:     normal_y <= wr_data[ppcr_pkg::NRM_WIDTH-1:0];
        ppcr_pkg::CFG_PLANE_OFFSET: plane_offset <= wr_data;
        ppcr_pkg::CFG_WORLD_FRIC:   world_friction <= wr_data[ppcr_pkg::FRIC_WIDTH-1:0];
        ppcr_pkg::CFG_WORLD_REST:   world_restitution <= wr_data[ppcr_pkg::REST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] nx64;
  logic signed [W-1:0] ny64;
  logic signed [W-1:0] off64;
  assign nx64  = W'(normal_x);
  assign ny64  = W'(normal_y);
  assign off64 = W'(plane_offset);

  // pipeline registers
  ppcr_pkg::pipe_t st  [N];
  ppcr_pkg::pipe_t nxt [N];
  logic            vld [N];
  logic            en  [N];

  // per-stage load enables: a stage loads when empty or when it moves on
  always_comb begin
    en[N-1] = !vld[N-1] || result.ready;
    for (int i = N - 2; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end
  assign particle.ready = en[0];

  always_comb begin
    logic [61:0]    o;
    logic [6:0]     bl;
    logic [W-1:0]   tb;
    logic [W-1:0]   tr;
    logic [W-1:0]   dr;
    logic [W-1:0]   j;
    logic signed [W-1:0] fx;
    logic signed [W-1:0] fy;

    // stage 0: capture, products for the plane distance
    nxt[0]        = st[0];
    nxt[0].px     = W'(particle.pos_x);
    nxt[0].py     = W'(particle.pos_y);
    nxt[0].qx     = W'(particle.prev_x);
    nxt[0].qy     = W'(particle.prev_y);
    nxt[0].rad    = $signed(W'(particle.radius));
    nxt[0].pinned = particle.pinned;
    nxt[0].lf     = particle.local_friction;
    nxt[0].lr     = particle.local_restitution;
    nxt[0].mp0    = ppcr_pkg::mul_lo(W'(particle.pos_x), nx64);
    nxt[0].mp1    = ppcr_pkg::mul_lo(W'(particle.pos_y), ny64);

    for (int i = 1; i < N; i++) nxt[i] = st[i-1];

    nxt[1].a = ppcr_pkg::mul_hi(st[0].mp0, ppcr_pkg::NRM_FRAC);
    nxt[1].b = ppcr_pkg::mul_hi(st[0].mp1, ppcr_pkg::NRM_FRAC);
    nxt[2].a = ppcr_pkg::sadd(st[1].a, st[1].b);
    nxt[3].pdist = ppcr_pkg::sadd(st[2].a, -off64);

    // penetration test and coefficient mix
    nxt[4].hit = !st[3].pinned && (st[3].pdist < st[3].rad);
    nxt[4].pen = ppcr_pkg::sadd(st[3].rad, -st[3].pdist);
    nxt[4].mu  = ppcr_pkg::FRIC_WIDTH'(({1'b0, world_friction} + {1'b0, st[3].lf}) >> 1);
    nxt[4].e   = (world_restitution < st[3].lr) ? world_restitution : st[3].lr;

    // push out along the normal
    nxt[5].mp0 = ppcr_pkg::mul_lo(nx64, st[4].pen);
    nxt[5].mp1 = ppcr_pkg::mul_lo(ny64, st[4].pen);
    nxt[6].a   = ppcr_pkg::mul_hi(st[5].mp0, ppcr_pkg::NRM_FRAC);
    nxt[6].b   = ppcr_pkg::mul_hi(st[5].mp1, ppcr_pkg::NRM_FRAC);
    nxt[7].npx = satpos(ppcr_pkg::sadd(st[6].px, st[6].a));
    nxt[7].npy = satpos(ppcr_pkg::sadd(st[6].py, st[6].b));

    // velocity and its normal part
    nxt[8].vx  = ppcr_pkg::sadd(st[7].npx, -st[7].qx);
    nxt[8].vy  = ppcr_pkg::sadd(st[7].npy, -st[7].qy);
    nxt[9].mp0 = ppcr_pkg::mul_lo(st[8].vx, nx64);
    nxt[9].mp1 = ppcr_pkg::mul_lo(st[8].vy, ny64);
    nxt[10].a  = ppcr_pkg::mul_hi(st[9].mp0, ppcr_pkg::NRM_FRAC);
    nxt[10].b  = ppcr_pkg::mul_hi(st[9].mp1, ppcr_pkg::NRM_FRAC);
    nxt[11].vn = ppcr_pkg::sadd(st[10].a, st[10].b);

    // restitution size, normal projection, friction limit
    nxt[12].mp0 = ppcr_pkg::mul_lo(-st[11].vn,
                    $signed({47'b0, st[11].e}) + (64'sd1 <<< ppcr_pkg::COEF_FRAC));
    nxt[12].mp1 = ppcr_pkg::mul_lo(st[11].vn, nx64);
    nxt[12].mp2 = ppcr_pkg::mul_lo(st[11].vn, ny64);
    nxt[12].mp3 = ppcr_pkg::mul_lo($signed({2'b0, ppcr_pkg::mag(st[11].vn)}),
                                   $signed({46'b0, st[11].mu}));
    nxt[13].m   = ppcr_pkg::mul_hi(st[12].mp0, ppcr_pkg::COEF_FRAC);
    nxt[13].a   = ppcr_pkg::mul_hi(st[12].mp1, ppcr_pkg::NRM_FRAC);
    nxt[13].b   = ppcr_pkg::mul_hi(st[12].mp2, ppcr_pkg::NRM_FRAC);
    nxt[13].lim = ppcr_pkg::mul_hi(st[12].mp3, ppcr_pkg::COEF_FRAC);

    // restitution impulse and tangent
    nxt[14].mp0 = ppcr_pkg::mul_lo(nx64, st[13].m);
    nxt[14].mp1 = ppcr_pkg::mul_lo(ny64, st[13].m);
    nxt[14].tx  = ppcr_pkg::sadd(st[13].vx, -st[13].a);
    nxt[14].ty  = ppcr_pkg::sadd(st[13].vy, -st[13].b);
    nxt[15].a   = ppcr_pkg::mul_hi(st[14].mp0, ppcr_pkg::NRM_FRAC);
    nxt[15].b   = ppcr_pkg::mul_hi(st[14].mp1, ppcr_pkg::NRM_FRAC);
    nxt[15].tnz = (st[14].tx != 0) || (st[14].ty != 0);

    // apply restitution, prescale tangent for the square
    nxt[16].nqx = (st[15].vn < 0) ? ppcr_pkg::sadd(st[15].qx, st[15].a) : st[15].qx;
    nxt[16].nqy = (st[15].vn < 0) ? ppcr_pkg::sadd(st[15].qy, st[15].b) : st[15].qy;
    o  = ppcr_pkg::mag(st[15].tx) | ppcr_pkg::mag(st[15].ty);
    bl = '0;
    for (int b = 0; b < 62; b++) if (o[b]) bl = 7'(b + 1);
    nxt[16].k  = (bl > 7'd31) ? 6'(bl - 7'd31) : 6'd0;
    nxt[16].sx = 31'(ppcr_pkg::mag(st[15].tx) >> nxt[16].k);
    nxt[16].sy = 31'(ppcr_pkg::mag(st[15].ty) >> nxt[16].k);

    nxt[17].sqx = 62'(st[16].sx) * 62'(st[16].sx);
    nxt[17].sqy = 62'(st[16].sy) * 62'(st[16].sy);
    nxt[18].rem = W'(st[17].sqx) + W'(st[17].sqy);
    nxt[18].res = '0;

    // integer square root, two result bits per stage
    for (int s = 0; s < SQRT_ST; s++) begin
      for (int t = 0; t < SQRT_STEPS; t++) begin
        tb = W'(1) << (62 - 2 * (s * SQRT_STEPS + t));
        tr = nxt[S_SQRT0+s].res + tb;
        if (nxt[S_SQRT0+s].rem >= tr) begin
          nxt[S_SQRT0+s].rem = nxt[S_SQRT0+s].rem - tr;
          nxt[S_SQRT0+s].res = (nxt[S_SQRT0+s].res >> 1) + tb;
        end else begin
          nxt[S_SQRT0+s].res = nxt[S_SQRT0+s].res >> 1;
        end
      end
    end

    // tangent length against the friction limit
    nxt[S_LEN].len = W'(st[S_LEN-1].res[31:0]) << st[S_LEN-1].k;
    nxt[S_LEN].le  = nxt[S_LEN].len <= st[S_LEN-1].lim;

    // scale both so the length fits 38 bits; the ratio can reach exactly 1.0
    bl = '0;
    for (int b = 0; b < W; b++) if (st[S_DSET-1].len[b]) bl = 7'(b + 1);
    j = (bl > 7'd38) ? W'(bl - 7'd38) : W'(0);
    nxt[S_DSET].ls = st[S_DSET-1].len >> j;
    dr             = st[S_DSET-1].lim >> j;
    nxt[S_DSET].q  = '0;
    if (dr >= nxt[S_DSET].ls) begin
      nxt[S_DSET].drem = dr - nxt[S_DSET].ls;
      nxt[S_DSET].q[0] = 1'b1;
    end else begin
      nxt[S_DSET].drem = dr;
    end

    // restoring divide for the Q1.24 ratio, two bits per stage
    for (int s = 0; s < DIV_ST; s++) begin
      for (int t = 0; t < DIV_STEPS; t++) begin
        dr = nxt[S_DIV0+s].drem << 1;
        if (dr >= nxt[S_DIV0+s].ls) begin
          nxt[S_DIV0+s].drem = dr - nxt[S_DIV0+s].ls;
          nxt[S_DIV0+s].q    = {nxt[S_DIV0+s].q[ppcr_pkg::RATIO_FRAC-1:0], 1'b1};
        end else begin
          nxt[S_DIV0+s].drem = dr;
          nxt[S_DIV0+s].q    = {nxt[S_DIV0+s].q[ppcr_pkg::RATIO_FRAC-1:0], 1'b0};
        end
      end
    end

    // clamped friction impulse
    nxt[S_QMUL].mp0 = ppcr_pkg::mul_lo(st[S_QMUL-1].tx, $signed(W'(st[S_QMUL-1].q)));
    nxt[S_QMUL].mp1 = ppcr_pkg::mul_lo(st[S_QMUL-1].ty, $signed(W'(st[S_QMUL-1].q)));
    nxt[S_QMUL+1].a = ppcr_pkg::mul_hi(st[S_QMUL].mp0, ppcr_pkg::RATIO_FRAC);
    nxt[S_QMUL+1].b = ppcr_pkg::mul_hi(st[S_QMUL].mp1, ppcr_pkg::RATIO_FRAC);
    fx = st[S_QMUL+1].le ? st[S_QMUL+1].tx : st[S_QMUL+1].a;
    fy = st[S_QMUL+1].le ? st[S_QMUL+1].ty : st[S_QMUL+1].b;
    if (st[S_QMUL+1].tnz) begin
      nxt[S_QMUL+2].nqx = ppcr_pkg::sadd(st[S_QMUL+1].nqx, -fx);
      nxt[S_QMUL+2].nqy = ppcr_pkg::sadd(st[S_QMUL+1].nqy, -fy);
    end

    // final select: untouched particle or response
    nxt[N-1].npx = st[N-2].hit ? st[N-2].npx : st[N-2].px;
    nxt[N-1].npy = st[N-2].hit ? st[N-2].npy : st[N-2].py;
    nxt[N-1].nqx = st[N-2].hit ? satpos(st[N-2].nqx) : st[N-2].qx;
    nxt[N-1].nqy = st[N-2].hit ? satpos(st[N-2].nqy) : st[N-2].qy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) vld[i] <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= particle.valid;
      for (int i = 1; i < N; i++) if (en[i]) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) if (en[i]) st[i] <= nxt[i];
  end

  assign result.valid      = vld[N-1];
  assign result.new_pos_x  = st[N-1].npx[POS_WIDTH-1:0];
  assign result.new_pos_y  = st[N-1].npy[POS_WIDTH-1:0];
  assign result.new_prev_x = st[N-1].nqx[POS_WIDTH-1:0];
  assign result.new_prev_y = st[N-1].nqy[POS_WIDTH-1:0];
  assign result.collided   = st[N-1].hit;

endmodule
`default_nettype wire
